// ----- rtl/core/descriptor_free_list_manager_top_assert.svh -----
// ----------------------------------------------------------------------------
// Descriptor free list manager: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_FREE_LIST_MANAGER_TOP_ASSERT_SVH
`define DESCRIPTOR_FREE_LIST_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DFLM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DFLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dflm_pkg.sv -----
// ----------------------------------------------------------------------------
// dflm_pkg
// Shared types and codes for the descriptor free list manager.
// ----------------------------------------------------------------------------
package dflm_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int ACT_W = 2;

    // action field codes
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LINK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_LINK  = 2'd2,
        OP_FREE  = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] link_next;
        logic             link_flag;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_chan_t;

    typedef struct packed {
        logic [CNT_W-1:0] size;
        logic [CNT_W-1:0] free_total;
    } back_stat_t;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] granted_index;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] freed_count;
    } rsp_t;

endpackage

// ----- rtl/core/dflm_intf.sv -----
// ----------------------------------------------------------------------------
// dflm channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface dflm_req_if;
    logic                        valid;
    logic                        ready;
    logic [dflm_pkg::ACT_W-1:0]  action;
    logic [dflm_pkg::IDX_W-1:0]  desc_index;
    logic [dflm_pkg::IDX_W-1:0]  link_next;
    logic                        link_has_next;

    modport source (output valid, action, desc_index, link_next, link_has_next,
                    input ready);
    modport sink   (input valid, action, desc_index, link_next, link_has_next,
                    output ready);
endinterface

interface dflm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [dflm_pkg::IDX_W-1:0]  granted_index;
    logic [dflm_pkg::CNT_W-1:0]  free_count;
    logic [dflm_pkg::CNT_W-1:0]  freed_count;

    modport source (output valid, status, granted_index, free_count, freed_count,
                    input ready);
    modport sink   (input valid, status, granted_index, free_count, freed_count,
                    output ready);
endinterface

interface dflm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dflm_pkg::CNT_W-1:0]  ring_size;

    modport source (output valid, ring_size, input ready);
    modport sink   (input valid, ring_size, output ready);
endinterface

// ----- rtl/core/dflm_front.sv -----
// ----------------------------------------------------------------------------
// dflm_front
// Takes requests and classifies them into queue operations; link and free
// with an index outside the queue, and the unused action, become no-ops.
// ----------------------------------------------------------------------------
module dflm_front (
    dflm_req_if.sink                   req,
    input  logic [dflm_pkg::CNT_W-1:0] size,
    input  logic                       q_full,
    output dflm_pkg::op_chan_t         push
);

    logic in_range;

    assign in_range  = {1'b0, req.desc_index} < size;
    assign req.ready = !q_full;

    always_comb
    begin
        push.valid        = req.valid && !q_full;
        push.op.idx       = req.desc_index;
        push.op.link_next = req.link_next;
        push.op.link_flag = req.link_has_next;
        unique case (req.action)
            dflm_pkg::ACT_ALLOC: push.op.kind = dflm_pkg::OP_ALLOC;
            dflm_pkg::ACT_LINK:  push.op.kind = in_range ? dflm_pkg::OP_LINK : dflm_pkg::OP_NOP;
            dflm_pkg::ACT_FREE:  push.op.kind = in_range ? dflm_pkg::OP_FREE : dflm_pkg::OP_NOP;
            default:             push.op.kind = dflm_pkg::OP_NOP;
        endcase
    end

endmodule

// ----- rtl/core/dflm_queue.sv -----
// ----------------------------------------------------------------------------
// dflm_queue
// Two-entry operation queue between the front and the back.
// ----------------------------------------------------------------------------
module dflm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  dflm_pkg::op_chan_t push,
    output logic               full,
    output dflm_pkg::op_chan_t head,
    input  logic               pop
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    dflm_pkg::op_t    entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.op;
        end
    end

endmodule

// ----- rtl/core/dflm_back.sv -----
// ----------------------------------------------------------------------------
// dflm_back
// Executes queued operations against the descriptor table and the free list
// head and count; owns the queue size register and the response register.
// ----------------------------------------------------------------------------
module dflm_back #(
    parameter int DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dflm_pkg::op_chan_t   head,
    output logic                 pop,
    dflm_cfg_if.sink             cfg,
    dflm_rsp_if.source           rsp,
    output dflm_pkg::back_stat_t stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = dflm_pkg::IDX_W;
    localparam int CW = dflm_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ALLOC = 3'b010,
        S_FREE  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   size_reg;
    logic [CW-1:0]   total_reg, total_next;
    logic [IW-1:0]   list_head_reg, list_head_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [CW-1:0]   freed_reg, freed_next;
    logic            rsp_valid_reg;
    dflm_pkg::rsp_t  rsp_data_reg, rsp_next;
    logic            load_rsp;
    logic [DEPTH-1:0] entry_valid_reg;

    // table word: {chain flag, next index}
    logic [IW:0]     mem_array [DEPTH];
    logic [IW:0]     rd_raw_reg;
    logic            rd_valid_reg;
    logic            rd_byp_reg;
    logic [IW:0]     rd_byp_word_reg;

    logic            we, re;
    logic [AW-1:0]   waddr, raddr;
    logic [IW:0]     wword;
    logic [IW:0]     rd_word;
    logic [IW-1:0]   rd_next;
    logic            rd_flag;
    logic [IW-1:0]   head_slot;
    logic [CW-1:0]   total_inc, freed_inc;
    logic            out_free;
    logic            cfg_fire;
    logic [CW-1:0]   cfg_eff;
    logic            stop;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = (state_reg == S_IDLE) && !head.valid && !rsp_valid_reg;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign cfg_eff   = (cfg.ring_size == '0)     ? CW'(1) :
                       (cfg.ring_size > DEPTH_C) ? DEPTH_C : cfg.ring_size;

    // unwritten entries read as their rebuilt value: next = index + 1, flag clear
    assign rd_word   = rd_byp_reg   ? rd_byp_word_reg :
                       rd_valid_reg ? rd_raw_reg :
                                      {1'b0, IW'(cur_reg[AW-1:0]) + IW'(1)};
    assign rd_next   = rd_word[IW-1:0];
    assign rd_flag   = rd_word[IW];
    assign head_slot = ({1'b0, list_head_reg} < DEPTH_C) ? list_head_reg : '0;
    assign total_inc = total_reg + CW'(1);
    assign freed_inc = freed_reg + CW'(1);
    assign stop      = !rd_flag || ({1'b0, rd_next} >= size_reg) || (total_inc >= size_reg);

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        list_head_next = list_head_reg;
        cur_next       = cur_reg;
        freed_next     = freed_reg;
        pop            = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = '0;
        raddr          = '0;
        wword          = '0;
        load_rsp       = 1'b0;
        rsp_next       = '{status: dflm_pkg::STATUS_OK, granted_index: '0,
                           free_count: total_reg, freed_count: '0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop = 1'b1;
                    unique case (head.op.kind)
                        dflm_pkg::OP_ALLOC:
                        begin
                            if (total_reg == '0)
                            begin
                                load_rsp        = 1'b1;
                                rsp_next.status = dflm_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = head_slot[AW-1:0];
                                cur_next   = head_slot;
                                state_next = S_ALLOC;
                            end
                        end
                        dflm_pkg::OP_LINK:
                        begin
                            we       = 1'b1;
                            waddr    = head.op.idx[AW-1:0];
                            wword    = {head.op.link_flag, head.op.link_next};
                            load_rsp = 1'b1;
                        end
                        dflm_pkg::OP_FREE:
                        begin
                            if (total_reg >= size_reg)
                            begin
                                load_rsp = 1'b1;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = head.op.idx[AW-1:0];
                                cur_next   = head.op.idx;
                                freed_next = '0;
                                state_next = S_FREE;
                            end
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                we                     = 1'b1;
                waddr                  = cur_reg[AW-1:0];
                list_head_next         = rd_next;
                total_next             = total_reg - CW'(1);
                load_rsp               = 1'b1;
                rsp_next.granted_index = cur_reg;
                rsp_next.free_count    = total_reg - CW'(1);
                state_next             = S_IDLE;
            end
            S_FREE:
            begin
                // push cur onto the list, keeping its chain flag
                we             = 1'b1;
                waddr          = cur_reg[AW-1:0];
                wword          = {rd_flag, list_head_reg};
                list_head_next = cur_reg;
                total_next     = total_inc;
                freed_next     = freed_inc;
                if (stop)
                begin
                    load_rsp             = 1'b1;
                    rsp_next.free_count  = total_inc;
                    rsp_next.freed_count = freed_inc;
                    state_next           = S_IDLE;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = rd_next[AW-1:0];
                    cur_next = rd_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            size_reg        <= DEPTH_C;
            total_reg       <= DEPTH_C;
            list_head_reg   <= '0;
            cur_reg         <= '0;
            freed_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            freed_reg <= freed_next;
            if (cfg_fire)
            begin
                size_reg        <= cfg_eff;
                total_reg       <= cfg_eff;
                list_head_reg   <= '0;
                entry_valid_reg <= '0;
            end
            else
            begin
                total_reg     <= total_next;
                list_head_reg <= list_head_next;
                if (we)
                begin
                    entry_valid_reg[waddr] <= 1'b1;
                end
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // table write and registered read; same-address write is forwarded
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wword;
        end
        if (re)
        begin
            rd_raw_reg      <= mem_array[raddr];
            rd_valid_reg    <= entry_valid_reg[raddr];
            rd_byp_reg      <= we && (waddr == raddr);
            rd_byp_word_reg <= wword;
        end
        if (load_rsp)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_data_reg.status;
    assign rsp.granted_index = rsp_data_reg.granted_index;
    assign rsp.free_count    = rsp_data_reg.free_count;
    assign rsp.freed_count   = rsp_data_reg.freed_count;

    assign stat.size       = size_reg;
    assign stat.free_total = total_reg;

endmodule

// ----- rtl/core/descriptor_free_list_manager_top.sv -----
// ----------------------------------------------------------------------------
// descriptor_free_list_manager_top
// Linked free list over a table of up to 64 queue descriptors.
// req carries one request (allocate, link, free chain); rsp returns exactly
// one response per request, in order. cfg writes the ring size, which rebuilds
// the list as descriptors 0..size-1; it is taken only while the block is
// empty, so writes wait until every response has been taken.
// A request is written into a two-entry queue when it is accepted; the execution
// unit picks it up once it is idle and its response register is free. Link and
// no-op requests are executed directly; allocate reads the table, then writes
// it (no read on an empty list); free chain reads and writes each descriptor
// walked (none on a full list), paced by the table's single read port and the
// dependent next index.
// Requests keep being accepted while the queue has room, even when rsp is
// stalled; the unit holds a finished response until rsp.ready.
// Reset gives size 64 (capped at MAX_DESCRIPTORS) and a full list at once.
// ----------------------------------------------------------------------------
module descriptor_free_list_manager_top #(
    parameter int MAX_DESCRIPTORS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    dflm_req_if.sink    req,
    dflm_rsp_if.source  rsp,
    dflm_cfg_if.sink    cfg
);

    localparam int DEPTH = (MAX_DESCRIPTORS < 64) ? MAX_DESCRIPTORS : 64;

    dflm_pkg::op_chan_t   q_push;
    dflm_pkg::op_chan_t   q_head;
    dflm_pkg::back_stat_t stat;
    logic                 q_full;
    logic                 q_pop;

    dflm_front u_front (
        .req    (req),
        .size   (stat.size),
        .q_full (q_full),
        .push   (q_push)
    );

    dflm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    dflm_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .pop   (q_pop),
        .cfg   (cfg),
        .rsp   (rsp),
        .stat  (stat)
    );

`include "descriptor_free_list_manager_top_assert.svh"

    `DFLM_ASSERT_IMPLY(a_free_within_size, rsp.valid, rsp.free_count <= stat.size,
                       "free count above queue size")
    `DFLM_ASSERT_IMPLY(a_empty_response,
                       rsp.valid && (rsp.status == dflm_pkg::STATUS_EMPTY),
                       (rsp.free_count == '0) && (rsp.granted_index == '0) &&
                       (rsp.freed_count == '0),
                       "bad empty response")
    `DFLM_ASSERT_IMPLY(a_freed_bound, rsp.valid, rsp.freed_count <= rsp.free_count,
                       "freed exceeds free count")
    `DFLM_ASSERT_NEXT(a_cfg_rebuild, cfg.valid && cfg.ready,
                      stat.free_total == stat.size, "list not full after size write")

endmodule
